[sv/lfs_pkg.sv]
package lfs_pkg;

   localparam int PWM_MAX_DEF    = 1000;
   localparam int LOST_LIMIT_DEF = 60;

   // angles in 1/16 degree
   localparam int HALF_TURN   = 2880;
   localparam int FULL_TURN   = 5760;
   localparam int LINE_CENTER = 350;
   localparam int HELD_ERROR  = 250;
   localparam int YAW_GAIN    = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 15;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE_SPEED      = 3'd0,
      CSR_PROP_GAIN       = 3'd1,
      CSR_DERIV_GAIN      = 3'd2,
      CSR_SEARCH_FRACTION = 3'd3,
      CSR_STEER_LIMIT     = 3'd4,
      CSR_SEARCH_SIDE     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_SEARCH  = 2'd0,
      PHASE_TRACK   = 2'd1,
      PHASE_RECOVER = 2'd2,
      PHASE_DONE    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [9:0]         base_speed;
      logic [13:0]        prop_gain;
      logic signed [14:0] deriv_gain;
      logic [8:0]         search_fraction;
      logic [9:0]         steer_limit;
      logic signed [1:0]  search_side;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic signed [12:0] heading;
      logic               line_valid;
      logic [9:0]         line_pos;
   } req_item_type;

   // operands and control for the correction: corr = (opa*opb + opc*opd) / 2^shift
   typedef struct packed {
      logic      stop;
      phase_type phase;
      logic      shift8;
      logic      clamp;
   } corr_ctl_type;

   typedef struct packed {
      corr_ctl_type       ctl;
      logic signed [16:0] opa;
      logic signed [11:0] opb;
      logic signed [14:0] opc;
      logic signed [11:0] opd;
   } dec_type;

   typedef struct packed {
      corr_ctl_type       ctl;
      logic signed [28:0] p1;
      logic signed [26:0] p2;
   } prod_type;

   typedef struct packed {
      logic [9:0] left_speed;
      logic [9:0] right_speed;
      phase_type  phase;
      logic       segment_done;
   } rsp_item_type;

   function automatic logic [9:0] eff_base(input logic [9:0] base, input logic [16:0] pwm_max);
      eff_base = ({7'b0, base} > pwm_max) ? pwm_max[9:0] : base;
   endfunction

endpackage

[sv/line_follow_pd_steering_unit.sv]
// Line-follower steering unit for a differential-drive robot.
// The req_ stream carries one control tick per item: the yaw sample, the line
// sensor position and its valid bit; req_tuser high begins a new segment and
// clears the tracking state. Each item yields exactly one rsp_ item with the
// left and right wheel PWM, the phase (search, tracking, yaw recovery, done)
// and the segment-done flag.
// Gains, base speed, search bias, steering limit and search side are set over
// the csr_ write port while the unit is idle; writes take effect at once.
// An item passes an input register, a decision stage that updates the
// tracking state, a multiplier stage and the result register. One item is
// taken every cycle unless the rsp_ side stalls. The rate is set by the
// decision stage, which reads and writes the tracking state for one item
// per cycle.
// A stalled rsp_ side fills the four stages; req_tready drops only once the
// result register holds an item nobody has taken, and no item is lost.
// Reset empties the pipeline, clears the tracking state and loads the default
// register values.
module line_follow_pd_steering_unit #(
   parameter int PWM_MAX    = lfs_pkg::PWM_MAX_DEF,
   parameter int LOST_LIMIT = lfs_pkg::LOST_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // heading[12:0], line_valid[13], line_pos[23:14]
   input  logic [23:0]                    req_tdata,
   // opcode
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // left_speed[9:0], right_speed[19:10], phase[21:20], segment_done[22]
   output logic [23:0]                    rsp_tdata,
   input  logic                           csr_we,
   input  logic [lfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lfs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfs_pkg::*;

   cfg_type      cfg_ff;
   req_item_type in_ff;
   logic         v0_ff, v1_ff, v2_ff, v3_ff;
   logic         ld0, ld1, ld2, ld3;
   dec_type      dec;
   prod_type     prod;
   rsp_item_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed      <= 10'd650;
         cfg_ff.prop_gain       <= 14'd512;
         cfg_ff.deriv_gain      <= '0;
         cfg_ff.search_fraction <= 9'd128;
         cfg_ff.steer_limit     <= 10'd800;
         cfg_ff.search_side     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BASE_SPEED:      cfg_ff.base_speed      <= csr_wdata[9:0];
            CSR_PROP_GAIN:       cfg_ff.prop_gain       <= csr_wdata[13:0];
            CSR_DERIV_GAIN:      cfg_ff.deriv_gain      <= csr_wdata[14:0];
            CSR_SEARCH_FRACTION: cfg_ff.search_fraction <= csr_wdata[8:0];
            CSR_STEER_LIMIT:     cfg_ff.steer_limit     <= csr_wdata[9:0];
            CSR_SEARCH_SIDE:     cfg_ff.search_side     <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // each stage loads when empty or when the stage after it moves on
   assign ld3 = !v3_ff || rsp_tready;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign ld0 = !v0_ff || ld1;
   assign req_tready = ld0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ld0) v0_ff <= req_tvalid;
         if (ld1) v1_ff <= v0_ff;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld0 && req_tvalid) begin
         in_ff.opcode     <= req_tuser;
         in_ff.heading    <= req_tdata[12:0];
         in_ff.line_valid <= req_tdata[13];
         in_ff.line_pos   <= req_tdata[23:14];
      end
   end

   lfs_decide #(
      .PWM_MAX    (PWM_MAX),
      .LOST_LIMIT (LOST_LIMIT)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (v0_ff),
      .in_item  (in_ff),
      .ld       (ld1),
      .dec      (dec)
   );

   lfs_mult u_mult (
      .clock (clock),
      .ld    (ld2 && v1_ff),
      .dec   (dec),
      .prod  (prod)
   );

   lfs_emit #(
      .PWM_MAX (PWM_MAX)
   ) u_emit (
      .clock  (clock),
      .ld     (ld3 && v2_ff),
      .cfg    (cfg_ff),
      .prod   (prod),
      .result (result)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {1'b0, result.segment_done, result.phase,
                        result.right_speed, result.left_speed};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with an empty result register");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.segment_done |->
         result.left_speed == '0 && result.right_speed == '0 && result.phase == PHASE_DONE)
      else $error("segment done without stopped motors");

endmodule

[sv/lfs_decide.sv]
module lfs_decide #(
   parameter int PWM_MAX    = lfs_pkg::PWM_MAX_DEF,
   parameter int LOST_LIMIT = lfs_pkg::LOST_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lfs_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   input  lfs_pkg::req_item_type in_item,
   input  logic                 ld,
   output lfs_pkg::dec_type     dec
);
   import lfs_pkg::*;

   localparam int LostW = $clog2(LOST_LIMIT + 1);
   localparam logic [LostW-1:0] LostMax = LostW'(LOST_LIMIT);
   localparam logic [16:0] PwmMax = 17'(PWM_MAX);

   logic signed [12:0] prev_heading_ff, prev_heading_in;
   logic signed [15:0] turned_ff, turned_in;
   logic signed [10:0] prev_err_ff, prev_err_in;
   logic [LostW-1:0]   lost_ff, lost_in;
   logic               seen_ff, seen_in;
   dec_type            dec_ff, dec_in;

   logic signed [13:0] step;
   logic signed [16:0] turn_sum;
   logic signed [16:0] yaw_err;
   logic signed [10:0] line_err;
   logic [8:0]         frac_eff;
   logic               take;

   assign take = ld && in_valid;

   always_comb begin
      prev_heading_in = prev_heading_ff;
      turned_in       = turned_ff;
      prev_err_in     = prev_err_ff;
      lost_in         = lost_ff;
      seen_in         = seen_ff;
      dec_in          = '0;
      dec_in.ctl.phase = PHASE_SEARCH;

      // heading step wrapped once into about half a turn
      step = {in_item.heading[12], in_item.heading} - {prev_heading_ff[12], prev_heading_ff};
      if (step > HALF_TURN) begin
         step = step - 14'(FULL_TURN);
      end
      if (step < -HALF_TURN) begin
         step = step + 14'(FULL_TURN);
      end
      turn_sum = {turned_ff[15], turned_ff} + {{3{step[13]}}, step};

      frac_eff = (cfg.search_fraction > 9'd256) ? 9'd256 : cfg.search_fraction;
      yaw_err  = '0;
      line_err = '0;

      if (in_item.opcode) begin
         prev_heading_in = in_item.heading;
         turned_in       = '0;
         prev_err_in     = '0;
         lost_in         = '0;
         seen_in         = 1'b0;
         dec_in.ctl.stop = 1'b1;
      end else begin
         prev_heading_in = in_item.heading;
         if (turn_sum > 17'sd32767) begin
            turned_in = 16'sh7fff;
         end else if (turn_sum < -17'sd32768) begin
            turned_in = 16'sh8000;
         end else begin
            turned_in = turn_sum[15:0];
         end

         if (seen_ff && !in_item.line_valid) begin
            dec_in.ctl.stop  = 1'b1;
            dec_in.ctl.phase = PHASE_DONE;
         end else begin
            seen_in = seen_ff | in_item.line_valid;
            if (!seen_in && cfg.search_side != 2'sd0) begin
               dec_in.ctl.phase  = PHASE_SEARCH;
               dec_in.ctl.shift8 = 1'b1;
               dec_in.opa = {7'b0, eff_base(cfg.base_speed, PwmMax)};
               dec_in.opb = cfg.search_side[1] ? -{3'b0, frac_eff} : {3'b0, frac_eff};
            end else begin
               if (!in_item.line_valid) begin
                  if (lost_ff < LostMax) begin
                     lost_in = lost_ff + 1'b1;
                  end
               end else begin
                  lost_in = '0;
               end

               if (lost_in >= LostMax) begin
                  // aim at half a turn of accumulated rotation
                  yaw_err = (turned_in > 16'sd0) ?
                            ({turned_in[15], turned_in} - 17'(HALF_TURN)) :
                            ({turned_in[15], turned_in} + 17'(HALF_TURN));
                  if (yaw_err > HALF_TURN) begin
                     yaw_err = yaw_err - 17'(FULL_TURN);
                  end
                  if (yaw_err < -HALF_TURN) begin
                     yaw_err = yaw_err + 17'(FULL_TURN);
                  end
                  dec_in.ctl.phase = PHASE_RECOVER;
                  dec_in.ctl.clamp = 1'b1;
                  dec_in.opa = yaw_err;
                  dec_in.opb = 12'(YAW_GAIN);
               end else begin
                  if (in_item.line_valid) begin
                     line_err = $signed({1'b0, in_item.line_pos}) - 11'(LINE_CENTER);
                  end else begin
                     line_err = prev_err_ff[10] ? -11'(HELD_ERROR) : 11'(HELD_ERROR);
                  end
                  prev_err_in = line_err;
                  dec_in.ctl.phase  = PHASE_TRACK;
                  dec_in.ctl.shift8 = 1'b1;
                  dec_in.ctl.clamp  = 1'b1;
                  dec_in.opa = {3'b0, cfg.prop_gain};
                  dec_in.opb = {line_err[10], line_err};
                  dec_in.opc = cfg.deriv_gain;
                  dec_in.opd = {line_err[10], line_err} - {prev_err_ff[10], prev_err_ff};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_heading_ff <= '0;
         turned_ff       <= '0;
         prev_err_ff     <= '0;
         lost_ff         <= '0;
         seen_ff         <= 1'b0;
      end else if (take) begin
         prev_heading_ff <= prev_heading_in;
         turned_ff       <= turned_in;
         prev_err_ff     <= prev_err_in;
         lost_ff         <= lost_in;
         seen_ff         <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

   a_lost_bounded: assert property (@(posedge clock) disable iff (reset) lost_ff <= LostMax)
      else $error("lost tick count beyond limit");

   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      take && in_item.opcode |=> turned_ff == '0 && lost_ff == '0 && !seen_ff
         && prev_err_ff == '0)
      else $error("segment begin did not clear state");

endmodule

[sv/lfs_mult.sv]
module lfs_mult (
   input  logic             clock,
   input  logic             ld,
   input  lfs_pkg::dec_type dec,
   output lfs_pkg::prod_type prod
);
   import lfs_pkg::*;

   prod_type prod_ff, prod_in;

   always_comb begin
      prod_in.ctl = dec.ctl;
      // operands sign extended to the product width, low bits of the product kept
      prod_in.p1  = {{12{dec.opa[16]}}, dec.opa} * {{17{dec.opb[11]}}, dec.opb};
      prod_in.p2  = {{12{dec.opc[14]}}, dec.opc} * {{15{dec.opd[11]}}, dec.opd};
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[sv/lfs_emit.sv]
module lfs_emit #(
   parameter int PWM_MAX = lfs_pkg::PWM_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  ld,
   input  lfs_pkg::cfg_type      cfg,
   input  lfs_pkg::prod_type     prod,
   output lfs_pkg::rsp_item_type result
);
   import lfs_pkg::*;

   localparam logic [16:0] PwmMax = 17'(PWM_MAX);

   rsp_item_type       res_ff, res_in;
   logic signed [29:0] acc, acc_rnd, quot, lim;
   logic signed [11:0] corr;
   logic signed [12:0] sum_l, sum_r;
   logic [9:0]         base;

   function automatic logic [9:0] clamp_pwm(input logic signed [12:0] v, input logic [16:0] pmax);
      if (v[12]) begin
         clamp_pwm = '0;
      end else if ({5'b0, v[11:0]} > pmax) begin
         clamp_pwm = pmax[9:0];
      end else begin
         clamp_pwm = v[9:0];
      end
   endfunction

   always_comb begin
      base = eff_base(cfg.base_speed, PwmMax);
      acc  = {prod.p1[28], prod.p1} + {{3{prod.p2[26]}}, prod.p2};
      // bias negative values so the shift truncates toward zero
      acc_rnd = acc;
      if (acc[29]) begin
         acc_rnd = prod.ctl.shift8 ? (acc + 30'sd255) : (acc + 30'sd15);
      end
      quot = prod.ctl.shift8 ? (acc_rnd >>> 8) : (acc_rnd >>> 4);
      lim  = $signed({20'b0, cfg.steer_limit});
      if (prod.ctl.clamp && quot > lim) begin
         quot = lim;
      end else if (prod.ctl.clamp && quot < -lim) begin
         quot = -lim;
      end
      corr  = quot[11:0];
      sum_l = $signed({3'b0, base}) + {corr[11], corr};
      sum_r = $signed({3'b0, base}) - {corr[11], corr};

      res_in.phase        = prod.ctl.phase;
      res_in.segment_done = (prod.ctl.phase == PHASE_DONE);
      if (prod.ctl.stop) begin
         res_in.left_speed  = '0;
         res_in.right_speed = '0;
      end else begin
         res_in.left_speed  = clamp_pwm(sum_l, PwmMax);
         res_in.right_speed = clamp_pwm(sum_r, PwmMax);
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

[dv/tb_line_follow_pd_steering_unit.sv]
module tb_line_follow_pd_steering_unit;
   import lfs_pkg::*;

   // keeps its own copy of the registers and tracking state, and holds the
   // wheel commands still owed by the unit, oldest first
   class wheel_cmd_board;
      cfg_type      cfg;
      int           heading_prev;
      int           turn_sum;
      int           err_prev;
      int           lost_count;
      bit           line_found;
      rsp_item_type cmds_due[$];
      int           fault_count;

      function new();
         cfg.base_speed      = 10'd650;
         cfg.prop_gain       = 14'd512;
         cfg.deriv_gain      = '0;
         cfg.search_fraction = 9'd128;
         cfg.steer_limit     = 10'd800;
         cfg.search_side     = '0;
         heading_prev = 0;
         turn_sum     = 0;
         err_prev     = 0;
         lost_count   = 0;
         line_found   = 1'b0;
         fault_count  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_BASE_SPEED:      cfg.base_speed = v[9:0];
            CSR_PROP_GAIN:       cfg.prop_gain = v[13:0];
            CSR_DERIV_GAIN:      cfg.deriv_gain = v[14:0];
            CSR_SEARCH_FRACTION: cfg.search_fraction = v[8:0];
            CSR_STEER_LIMIT:     cfg.steer_limit = v[9:0];
            CSR_SEARCH_SIDE:     cfg.search_side = v[1:0];
            default: ;
         endcase
      endfunction

      function int half_wrap(int d);
         if (d > HALF_TURN) d -= FULL_TURN;
         if (d < -HALF_TURN) d += FULL_TURN;
         return d;
      endfunction

      function longint limit_corr(longint v);
         longint lim;
         lim = longint'(cfg.steer_limit);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function int pwm_of(longint v);
         if (v > PWM_MAX_DEF) v = PWM_MAX_DEF;
         if (v < 0) v = 0;
         return int'(v);
      endfunction

      function longint base_eff();
         return (int'(cfg.base_speed) > PWM_MAX_DEF) ? longint'(PWM_MAX_DEF)
                                                     : longint'(cfg.base_speed);
      endfunction

      function void push_drive(longint corr, phase_type ph);
         rsp_item_type c;
         c = '0;
         c.left_speed  = 10'(pwm_of(base_eff() + corr));
         c.right_speed = 10'(pwm_of(base_eff() - corr));
         c.phase       = ph;
         cmds_due.push_back(c);
      endfunction

      function void take_tick(req_item_type it);
         rsp_item_type c;
         int           side;
         int           total;
         int           err;
         int           frac;
         longint       bias;
         longint       acc;
         c = '0;
         side = int'(cfg.search_side);
         if (it.opcode) begin
            heading_prev = int'(it.heading);
            turn_sum     = 0;
            err_prev     = 0;
            lost_count   = 0;
            line_found   = 1'b0;
            c.phase      = PHASE_SEARCH;
            cmds_due.push_back(c);
            return;
         end
         total = turn_sum + half_wrap(int'(it.heading) - heading_prev);
         heading_prev = int'(it.heading);
         if (total > 32767) total = 32767;
         if (total < -32768) total = -32768;
         turn_sum = total;

         // losing the line once found stops the motors, re-checked every tick
         if (line_found && !it.line_valid) begin
            c.phase        = PHASE_DONE;
            c.segment_done = 1'b1;
            cmds_due.push_back(c);
            return;
         end
         if (it.line_valid) line_found = 1'b1;

         if (!line_found && side != 0) begin
            frac = (int'(cfg.search_fraction) > 256) ? 256 : int'(cfg.search_fraction);
            bias = (base_eff() * frac) / 256;
            if (side < 0) bias = -bias;
            push_drive(bias, PHASE_SEARCH);
            return;
         end

         if (!it.line_valid) begin
            if (lost_count < LOST_LIMIT_DEF) lost_count++;
         end else begin
            lost_count = 0;
         end

         if (lost_count >= LOST_LIMIT_DEF) begin
            err = (turn_sum > 0) ? turn_sum - HALF_TURN : turn_sum + HALF_TURN;
            err = half_wrap(err);
            push_drive(limit_corr((longint'(err) * YAW_GAIN) / 16), PHASE_RECOVER);
            return;
         end

         // a never-seen line is tracked with a held error on the side of the last one
         err = it.line_valid ? int'(it.line_pos) - LINE_CENTER
                             : (err_prev >= 0 ? HELD_ERROR : -HELD_ERROR);
         acc = longint'(cfg.prop_gain) * longint'(err)
             + longint'(cfg.deriv_gain) * longint'(err - err_prev);
         err_prev = err;
         push_drive(limit_corr(acc / 256), PHASE_TRACK);
      endfunction

      function void flag(string what, logic [9:0] want, logic [9:0] got);
         fault_count++;
         if (fault_count <= 40)
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void match_cmd(logic [23:0] d);
         rsp_item_type want;
         if (cmds_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 40)
               $display("%0t unexpected result: expected none, actual %h", $time, d);
            return;
         end
         want = cmds_due.pop_front();
         if (d[9:0] !== want.left_speed) flag("left_speed", want.left_speed, d[9:0]);
         if (d[19:10] !== want.right_speed) flag("right_speed", want.right_speed, d[19:10]);
         if (d[21:20] !== want.phase) flag("phase", 10'(want.phase), 10'(d[21:20]));
         if (d[22] !== want.segment_done)
            flag("segment_done", 10'(want.segment_done), 10'(d[22]));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wheel_cmd_board board;
   bit             idle_on;
   bit             hold_pending;
   int             hold_left;
   int             stall_left;

   line_follow_pd_steering_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver pacing: one long hold-off on request, otherwise short random stalls
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = 48;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.match_cmd(rsp_tdata);
   end

   task automatic send_tick(req_item_type it);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {it.line_pos, it.line_valid, it.heading};
      do @(posedge clock); while (!req_tready);
      board.take_tick(it);
   endtask

   task automatic drive(bit op, int heading, bit valid, int pos);
      req_item_type it;
      it.opcode     = op;
      it.heading    = 13'(heading);
      it.line_valid = valid;
      it.line_pos   = 10'(pos);
      send_tick(it);
   endtask

   // stop offering, then wait for every owed command and the pipeline to empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.cmds_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   task automatic load_cfg(cfg_type c);
      put_reg(CSR_BASE_SPEED, {5'd0, c.base_speed});
      put_reg(CSR_PROP_GAIN, {1'b0, c.prop_gain});
      put_reg(CSR_DERIV_GAIN, c.deriv_gain);
      put_reg(CSR_SEARCH_FRACTION, {6'd0, c.search_fraction});
      put_reg(CSR_STEER_LIMIT, {5'd0, c.steer_limit});
      put_reg(CSR_SEARCH_SIDE, {13'd0, c.search_side});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type make_cfg(int b, int p, int d, int f, int l, int s);
      cfg_type c;
      c.base_speed      = 10'(b);
      c.prop_gain       = 14'(p);
      c.deriv_gain      = 15'(d);
      c.search_fraction = 9'(f);
      c.steer_limit     = 10'(l);
      c.search_side     = 2'(s);
      return c;
   endfunction

   function automatic cfg_type pick_cfg(bit no_search);
      cfg_type c;
      case ($urandom_range(0, 3))
         0: c.base_speed = 10'd0;
         1: c.base_speed = 10'd1023;
         2: c.base_speed = 10'd1000;
         default: c.base_speed = 10'($urandom_range(200, 900));
      endcase
      case ($urandom_range(0, 3))
         0: c.prop_gain = 14'd0;
         1: c.prop_gain = 14'd16383;
         default: c.prop_gain = 14'($urandom_range(0, 1500));
      endcase
      case ($urandom_range(0, 4))
         0: c.deriv_gain = -15'sd16384;
         1: c.deriv_gain = 15'sd16383;
         2: c.deriv_gain = '0;
         default: c.deriv_gain = 15'(int'($urandom_range(0, 4095)) - 2048);
      endcase
      case ($urandom_range(0, 3))
         0: c.search_fraction = 9'd0;
         1: c.search_fraction = 9'd256;
         2: c.search_fraction = 9'd511;
         default: c.search_fraction = 9'($urandom_range(0, 511));
      endcase
      case ($urandom_range(0, 3))
         0: c.steer_limit = 10'd0;
         1: c.steer_limit = 10'd1023;
         2: c.steer_limit = 10'd1000;
         default: c.steer_limit = 10'($urandom_range(50, 900));
      endcase
      c.search_side = no_search ? 2'd0 : 2'($urandom_range(0, 3));
      return c;
   endfunction

   // one segment: begin, a lost stretch, tracking, then a random tail;
   // now and then an item is swapped for noise, a stray begin among it
   task automatic run_segment(output int used);
      req_item_type it;
      int           lost_len;
      int           seen_len;
      int           tail_len;
      int           spin;
      int           step;
      int           h;
      int           r;
      r = $urandom_range(0, 9);
      if (r < 4) lost_len = $urandom_range(0, 5);
      else if (r < 7) lost_len = $urandom_range(6, 30);
      else lost_len = $urandom_range(58, 70);
      seen_len = $urandom_range(0, 25);
      tail_len = $urandom_range(0, 4);
      spin = 0;
      if ($urandom_range(0, 2) == 0)
         spin = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2000, 2880));
      h = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
      drive(1'b1, h, 1'($urandom_range(0, 1)), int'($urandom_range(0, 1023)));
      for (int k = 0; k < lost_len + seen_len + tail_len; k++) begin
         if (spin != 0) step = spin;
         else if ($urandom_range(0, 19) == 0) step = int'($urandom_range(0, 11520)) - 5760;
         else step = int'($urandom_range(0, 600)) - 300;
         h += step;
         while (h > HALF_TURN) h -= FULL_TURN;
         while (h < -HALF_TURN) h += FULL_TURN;
         it.opcode  = 1'b0;
         it.heading = 13'(h);
         if (k < lost_len) begin
            it.line_valid = 1'b0;
            it.line_pos   = 10'($urandom_range(0, 1023));
         end else begin
            it.line_valid = (k < lost_len + seen_len) ? 1'b1 : 1'($urandom_range(0, 1));
            it.line_pos   = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                            : $urandom_range(290, 410));
         end
         if ($urandom_range(0, 14) == 0) begin
            it.opcode     = ($urandom_range(0, 3) == 0);
            it.heading    = 13'($urandom);
            it.line_valid = 1'($urandom);
            it.line_pos   = 10'($urandom);
         end
         send_tick(it);
      end
      used = 1 + lost_len + seen_len + tail_len;
   endtask

   initial begin
      int count;
      int used;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      idle_on      = 1'b0;
      hold_pending = 1'b0;
      hold_left    = 0;
      stall_left   = 0;
      board        = new();
      reset        = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // search right at full bias, saturated tracking, done not latched
      load_cfg(make_cfg(1023, 16383, -16384, 511, 1000, 1));
      drive(1'b1, -4096, 1'b0, 0);
      drive(1'b0, 4095, 1'b0, 1023);
      drive(1'b0, -2880, 1'b0, 0);
      drive(1'b0, 2880, 1'b1, 1023);
      drive(1'b0, 2880, 1'b1, 0);
      drive(1'b0, 0, 1'b1, 350);
      drive(1'b0, 16, 1'b0, 700);
      drive(1'b0, 32, 1'b1, 349);
      drive(1'b1, 0, 1'b1, 1023);
      settle();
      // side code -2 acts as left, zero base and zero limit
      load_cfg(make_cfg(0, 0, 16383, 256, 0, -2));
      drive(1'b1, 100, 1'b0, 0);
      drive(1'b0, -100, 1'b0, 512);
      drive(1'b0, 2000, 1'b1, 0);
      drive(1'b0, 2100, 1'b1, 1023);
      settle();
      // no search side: held error until the line shows up
      load_cfg(make_cfg(650, 512, 300, 128, 800, 0));
      drive(1'b1, 0, 1'b0, 0);
      drive(1'b0, 10, 1'b0, 0);
      drive(1'b0, 20, 1'b0, 0);
      drive(1'b0, 30, 1'b1, 100);
      drive(1'b0, 40, 1'b0, 0);
      settle();
      load_cfg(make_cfg(1000, 300, -100, 0, 300, -1));
      drive(1'b1, 0, 1'b0, 0);
      drive(1'b0, 5, 1'b0, 0);
      drive(1'b0, 10, 1'b1, 360);
      settle();

      for (int p = 0; p < 6; p++) begin
         load_cfg(pick_cfg(p == 0 || p == 3));
         if (p == 1) hold_pending = 1'b1;
         count = 0;
         while (count < 38) begin
            idle_on = (p != 5) && ($urandom_range(0, 3) != 0);
            run_segment(used);
            count += used;
         end
         settle();
      end

      if (board.fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
